/* rtl/bfie_pkg.sv */
// Shared command codes, status codes and stream widths for the instruction executor.
package bfie_pkg;

  localparam int unsigned InDataW   = 32;
  localparam int unsigned OutDataW  = 32;
  localparam int unsigned OutUserW  = 2;
  localparam int unsigned PosW      = 16;
  localparam int unsigned CellW     = 8;
  localparam int unsigned NestW     = 16;

  localparam logic [7:0] CMD_PTR_INC  = 8'h3E;  // '>'
  localparam logic [7:0] CMD_PTR_DEC  = 8'h3C;  // '<'
  localparam logic [7:0] CMD_CELL_INC = 8'h2B;  // '+'
  localparam logic [7:0] CMD_CELL_DEC = 8'h2D;  // '-'
  localparam logic [7:0] CMD_OUTPUT   = 8'h2E;  // '.'
  localparam logic [7:0] CMD_INPUT    = 8'h2C;  // ','
  localparam logic [7:0] CMD_LOOP_BEG = 8'h5B;  // '['
  localparam logic [7:0] CMD_LOOP_END = 8'h5D;  // ']'

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_PAST_END   = 3'd1,
    ST_BELOW_ZERO = 3'd2,
    ST_UNMATCHED  = 3'd3,
    ST_OVERFLOW   = 3'd4,
    ST_HALTED     = 3'd5
  } status_e;

endpackage

/* rtl/bfie_tape.sv */
// Tape memory with registered read, write-to-read forwarding and a high-water mark.
module bfie_tape import bfie_pkg::*; #(
  parameter int unsigned TAPE_CELLS = 32768
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rd_en_i,
  input  logic [$clog2(TAPE_CELLS)-1:0] rd_addr_i,
  input  logic                          wr_en_i,
  input  logic [$clog2(TAPE_CELLS)-1:0] wr_addr_i,
  input  logic [CellW-1:0]              wr_data_i,
  output logic [CellW-1:0]              cell_o
);

  localparam int unsigned HwW  = $clog2(TAPE_CELLS + 1);

  logic [CellW-1:0] mem [TAPE_CELLS];
  logic [CellW-1:0] rdata_q;
  logic [CellW-1:0] fwd_data_q;
  logic             fwd_q;
  logic             fresh_q;
  logic [HwW-1:0]   hw_q, hw_d;

  always_comb begin
    hw_d = hw_q;
    if (wr_en_i && (HwW'(wr_addr_i) == hw_q)) begin
      hw_d = hw_q + HwW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hw_q    <= '0;
      fwd_q   <= 1'b0;
      fresh_q <= 1'b1;
    end else begin
      hw_q <= hw_d;
      if (rd_en_i) begin
        fwd_q   <= wr_en_i && (wr_addr_i == rd_addr_i);
        fresh_q <= HwW'(rd_addr_i) >= hw_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rdata_q    <= mem[rd_addr_i];
      fwd_data_q <= wr_data_i;
    end
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  assign cell_o = fwd_q ? fwd_data_q : (fresh_q ? '0 : rdata_q);

endmodule

/* rtl/bfie_stack.sv */
// Loop-start stack memory with registered top read and push forwarding.
module bfie_stack import bfie_pkg::*; #(
  parameter int unsigned LOOP_DEPTH = 64
) (
  input  logic                                                  clk_i,
  input  logic                                                  rst_ni,
  input  logic                                                  rd_en_i,
  input  logic [((LOOP_DEPTH > 1) ? $clog2(LOOP_DEPTH) : 1)-1:0] rd_idx_i,
  input  logic                                                  push_en_i,
  input  logic [((LOOP_DEPTH > 1) ? $clog2(LOOP_DEPTH) : 1)-1:0] push_idx_i,
  input  logic [PosW-1:0]                                       push_data_i,
  output logic [PosW-1:0]                                       top_o
);

  logic [PosW-1:0] mem [LOOP_DEPTH];
  logic [PosW-1:0] rdata_q;
  logic [PosW-1:0] fwd_data_q;
  logic            fwd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= push_en_i && (push_idx_i == rd_idx_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rdata_q    <= mem[rd_idx_i];
      fwd_data_q <= push_data_i;
    end
    if (push_en_i) begin
      mem[push_idx_i] <= push_data_i;
    end
  end

  assign top_o = fwd_q ? fwd_data_q : rdata_q;

endmodule

/* rtl/brainfuck_instruction_executor.sv */
// Top level: command execute stage, state registers and output register.
//
// Usage: each slave-side request carries one program byte, the program position
// after it and an input byte. Every request yields exactly one master-side
// result with the emitted byte, a jump target and a status code.
// Pipeline: an accepted request is registered into the execute stage along with
// its memory reads, and its result then loads into the output register.
// Throughput: one request per cycle while results are taken. The cell and the stack top come from
// synchronous memories read at accept time; a write-back of the command ahead
// to the same entry is forwarded, so back-to-back commands never wait.
// Reset: the pointer, loop count, skip mode and halt clear at once; the tape
// reads as zero beyond a high-water mark, so no clearing pass is needed and a
// request may be sent in the first cycle after reset.
// Stall: when the receiver holds tready low, the output register keeps its
// result, the execute stage holds one more command and tready on the slave
// side then drops until the result is taken.
// A fault (pointer off the tape, unmatched ']', stack overflow) is sticky:
// every later request returns the halted status until reset.
module brainfuck_instruction_executor import bfie_pkg::*; #(
  parameter int unsigned TAPE_CELLS = 32768,
  parameter int unsigned LOOP_DEPTH = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [InDataW-1:0]  s_axis_tdata_i,  // instr[7:0], position[23:8], input_byte[31:24]
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o,  // out_byte[7:0], jump_target[23:8], status[26:24]
  output logic [OutUserW-1:0] m_axis_tuser_o   // out_valid[0], jump_valid[1]
);

  localparam int unsigned PtrW = $clog2(TAPE_CELLS);
  localparam int unsigned CntW = $clog2(LOOP_DEPTH + 1);
  localparam int unsigned IdxW = (LOOP_DEPTH > 1) ? $clog2(LOOP_DEPTH) : 1;

  logic             s_fire, e_fire, e_adv;
  logic             e_valid_q;
  logic [7:0]       e_instr_q;
  logic [PosW-1:0]  e_pos_q;
  logic [CellW-1:0] e_inb_q;

  logic [PtrW-1:0]  ptr_q, ptr_d;
  logic             skip_q, skip_d;
  logic [NestW-1:0] nest_q, nest_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             halt_q, halt_d;

  logic [CellW-1:0] cur_cell, cell_new;
  logic [PosW-1:0]  top;
  logic             push;

  logic             ov_d, jv_d;
  logic [CellW-1:0] ob_d;
  logic [PosW-1:0]  jt_d;
  status_e          st_d;

  logic             out_valid_q;
  logic             ov_q, jv_q;
  logic [CellW-1:0] ob_q;
  logic [PosW-1:0]  jt_q;
  status_e          st_q;

  assign e_adv           = ~out_valid_q | m_axis_tready_i;
  assign e_fire          = e_valid_q & e_adv;
  assign s_axis_tready_o = ~e_valid_q | e_adv;
  assign s_fire          = s_axis_tvalid_i & s_axis_tready_o;

  always_comb begin
    ptr_d    = ptr_q;
    skip_d   = skip_q;
    nest_d   = nest_q;
    cnt_d    = cnt_q;
    halt_d   = halt_q;
    cell_new = cur_cell;
    push     = 1'b0;
    ov_d     = 1'b0;
    ob_d     = '0;
    jv_d     = 1'b0;
    jt_d     = '0;
    st_d     = ST_OK;
    if (e_fire) begin
      if (halt_q) begin
        st_d = ST_HALTED;
      end else if (skip_q) begin
        if (e_instr_q == CMD_LOOP_BEG) begin
          if (nest_q != '1) begin
            nest_d = nest_q + NestW'(1);
          end
        end else if (e_instr_q == CMD_LOOP_END) begin
          if (nest_q != '0) begin
            nest_d = nest_q - NestW'(1);
          end else begin
            skip_d = 1'b0;
          end
        end
      end else begin
        case (e_instr_q)
          CMD_PTR_INC: begin
            if (ptr_q == PtrW'(TAPE_CELLS - 1)) begin
              halt_d = 1'b1;
              st_d   = ST_PAST_END;
            end else begin
              ptr_d = ptr_q + PtrW'(1);
            end
          end
          CMD_PTR_DEC: begin
            if (ptr_q == '0) begin
              halt_d = 1'b1;
              st_d   = ST_BELOW_ZERO;
            end else begin
              ptr_d = ptr_q - PtrW'(1);
            end
          end
          CMD_CELL_INC: cell_new = cur_cell + CellW'(1);
          CMD_CELL_DEC: cell_new = cur_cell - CellW'(1);
          CMD_OUTPUT: begin
            ov_d = 1'b1;
            ob_d = cur_cell;
          end
          CMD_INPUT: cell_new = e_inb_q;
          CMD_LOOP_BEG: begin
            if (cur_cell == '0) begin
              skip_d = 1'b1;
              nest_d = '0;
            end else if (cnt_q == CntW'(LOOP_DEPTH)) begin
              halt_d = 1'b1;
              st_d   = ST_OVERFLOW;
            end else begin
              push  = 1'b1;
              cnt_d = cnt_q + CntW'(1);
            end
          end
          CMD_LOOP_END: begin
            if (cnt_q == '0) begin
              halt_d = 1'b1;
              st_d   = ST_UNMATCHED;
            end else if (cur_cell != '0) begin
              jv_d = 1'b1;
              jt_d = top;
            end else begin
              cnt_d = cnt_q - CntW'(1);
            end
          end
          default: ;
        endcase
      end
    end
  end

  bfie_tape #(
    .TAPE_CELLS(TAPE_CELLS)
  ) u_tape (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (s_fire),
    .rd_addr_i (ptr_d),
    .wr_en_i   (e_fire),
    .wr_addr_i (ptr_q),
    .wr_data_i (cell_new),
    .cell_o    (cur_cell)
  );

  logic [CntW-1:0] top_cnt;
  assign top_cnt = cnt_d - CntW'(1);

  bfie_stack #(
    .LOOP_DEPTH(LOOP_DEPTH)
  ) u_stack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (s_fire),
    .rd_idx_i    (top_cnt[IdxW-1:0]),
    .push_en_i   (push),
    .push_idx_i  (cnt_q[IdxW-1:0]),
    .push_data_i (e_pos_q),
    .top_o       (top)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      ptr_q       <= '0;
      skip_q      <= 1'b0;
      nest_q      <= '0;
      cnt_q       <= '0;
      halt_q      <= 1'b0;
    end else begin
      e_valid_q   <= s_fire | (e_valid_q & ~e_adv);
      out_valid_q <= e_fire | (out_valid_q & ~m_axis_tready_i);
      ptr_q       <= ptr_d;
      skip_q      <= skip_d;
      nest_q      <= nest_d;
      cnt_q       <= cnt_d;
      halt_q      <= halt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      e_instr_q <= s_axis_tdata_i[7:0];
      e_pos_q   <= s_axis_tdata_i[23:8];
      e_inb_q   <= s_axis_tdata_i[31:24];
    end
    if (e_fire) begin
      ov_q <= ov_d;
      ob_q <= ob_d;
      jv_q <= jv_d;
      jt_q <= jt_d;
      st_q <= st_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'b0, st_q, jt_q, ob_q};
  assign m_axis_tuser_o  = {jv_q, ov_q};

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the instruction executor: program streams, tape and loop model.
module tb_top import bfie_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TapeCells = 32768;
  localparam int unsigned LoopDepth = 64;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned RandomCmds = 440;

  typedef struct packed {
    logic [7:0]  input_byte;
    logic [15:0] position;
    logic [7:0]  instr;
  } cmd_req_t;

  typedef struct packed {
    logic        out_valid;
    logic [7:0]  out_byte;
    logic        jump_valid;
    logic [15:0] jump_target;
    status_e     status;
  } exec_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_valid = 1'b0;
  logic                s_ready;
  logic [InDataW-1:0]  s_data = '0;
  logic                m_valid;
  logic                m_ready = 1'b0;
  logic [OutDataW-1:0] m_data;
  logic [OutUserW-1:0] m_user;

  brainfuck_instruction_executor #(
    .TAPE_CELLS(TapeCells),
    .LOOP_DEPTH(LoopDepth)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data),
    .m_axis_tuser_o (m_user)
  );

  // predicted executor state
  logic [7:0]  tape_mem [TapeCells];
  int unsigned cell_ptr = 0;
  bit          skip_mode = 1'b0;
  int unsigned skip_depth = 0;
  logic [15:0] loop_starts [LoopDepth];
  int unsigned loop_count = 0;
  bit          halt_flag = 1'b0;

  cmd_req_t     pending_q [$];
  exec_result_t expected_results_q [$];
  cmd_req_t     cur_req;
  exec_result_t want;
  int unsigned  in_gap = 0;
  int unsigned  out_gap = 0;
  int unsigned  hold_left = 0;
  int unsigned  hold_reqs = 0;
  int unsigned  hold_seen = 0;
  int unsigned  mismatch_count = 0;
  int unsigned  cmds_sent = 0;
  bit           steady = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10ms;
    $display("FAILURE");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic bit is_command(logic [7:0] c);
    return c == CMD_PTR_INC || c == CMD_PTR_DEC || c == CMD_CELL_INC ||
           c == CMD_CELL_DEC || c == CMD_OUTPUT || c == CMD_INPUT ||
           c == CMD_LOOP_BEG || c == CMD_LOOP_END;
  endfunction

  function automatic exec_result_t execute_command(cmd_req_t r);
    exec_result_t res;
    res.out_valid   = 1'b0;
    res.out_byte    = '0;
    res.jump_valid  = 1'b0;
    res.jump_target = '0;
    res.status      = ST_OK;
    if (halt_flag) begin
      res.status = ST_HALTED;
      return res;
    end
    if (skip_mode) begin
      if (r.instr == CMD_LOOP_BEG) begin
        if (skip_depth < 16'hFFFF) skip_depth++;
      end else if (r.instr == CMD_LOOP_END) begin
        if (skip_depth > 0) skip_depth--;
        else skip_mode = 1'b0;
      end
      return res;
    end
    case (r.instr)
      CMD_PTR_INC: begin
        if (cell_ptr == TapeCells - 1) res.status = ST_PAST_END;
        else cell_ptr++;
      end
      CMD_PTR_DEC: begin
        if (cell_ptr == 0) res.status = ST_BELOW_ZERO;
        else cell_ptr--;
      end
      CMD_CELL_INC: tape_mem[cell_ptr] = tape_mem[cell_ptr] + 8'd1;
      CMD_CELL_DEC: tape_mem[cell_ptr] = tape_mem[cell_ptr] - 8'd1;
      CMD_OUTPUT: begin
        res.out_valid = 1'b1;
        res.out_byte  = tape_mem[cell_ptr];
      end
      CMD_INPUT: tape_mem[cell_ptr] = r.input_byte;
      CMD_LOOP_BEG: begin
        if (tape_mem[cell_ptr] == 8'd0) begin
          skip_mode  = 1'b1;
          skip_depth = 0;
        end else if (loop_count >= LoopDepth) begin
          res.status = ST_OVERFLOW;
        end else begin
          loop_starts[loop_count] = r.position;
          loop_count++;
        end
      end
      CMD_LOOP_END: begin
        if (loop_count == 0) begin
          res.status = ST_UNMATCHED;
        end else if (tape_mem[cell_ptr] != 8'd0) begin
          res.jump_valid  = 1'b1;
          res.jump_target = loop_starts[loop_count - 1];
        end else begin
          loop_count--;
        end
      end
      default: ;
    endcase
    if (res.status != ST_OK) halt_flag = 1'b1;
    return res;
  endfunction

  task automatic report_mismatch(string field, int unsigned got, int unsigned exp_val);
    if (mismatch_count < 40)
      $display("%0t mismatch in %s: got 0x%0h, expected 0x%0h", $realtime, field, got, exp_val);
    mismatch_count++;
  endtask

  // sender: offer queued requests, predict each one as it is accepted
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid <= 1'b0;
      s_data  <= '0;
      in_gap = 0;
    end else begin
      if (s_valid && s_ready) expected_results_q.push_back(execute_command(cur_req));
      if (!s_valid || s_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          s_valid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          cur_req = pending_q.pop_front();
          s_valid <= 1'b1;
          s_data  <= cur_req;
          in_gap = pick_gap();
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: check results, stall at random, hold off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_ready <= 1'b0;
      out_gap = 0;
      hold_left = 0;
    end else begin
      if (m_valid && m_ready) begin
        if (expected_results_q.size() == 0) begin
          report_mismatch("unexpected result", m_data, 0);
        end else begin
          want = expected_results_q.pop_front();
          if (m_user[0] !== want.out_valid)
            report_mismatch("out_valid", m_user[0], want.out_valid);
          if (m_data[7:0] !== want.out_byte)
            report_mismatch("out_byte", m_data[7:0], want.out_byte);
          if (m_user[1] !== want.jump_valid)
            report_mismatch("jump_valid", m_user[1], want.jump_valid);
          if (m_data[23:8] !== want.jump_target)
            report_mismatch("jump_target", m_data[23:8], want.jump_target);
          if (m_data[26:24] !== want.status)
            report_mismatch("status", m_data[26:24], want.status);
        end
        out_gap = pick_gap();
      end
      if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        m_ready <= 1'b0;
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  task automatic push_full(logic [7:0] c, logic [15:0] pos, logic [7:0] inb);
    cmd_req_t r;
    r.instr      = c;
    r.position   = pos;
    r.input_byte = inb;
    pending_q.push_back(r);
    if (is_command(c)) cmds_sent++;
  endtask

  task automatic push_cmd(logic [7:0] c);
    push_full(c, 16'($urandom), 8'($urandom));
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom); while (is_command(b));
    return b;
  endfunction

  function automatic logic [7:0] skip_byte();
    logic [7:0] b;
    do b = 8'($urandom); while (b == CMD_LOOP_BEG || b == CMD_LOOP_END);
    return b;
  endfunction

  function automatic logic [7:0] cell_op();
    case ($urandom_range(0, 4))
      0: return CMD_CELL_INC;
      1: return CMD_CELL_DEC;
      2: return CMD_OUTPUT;
      3: return CMD_INPUT;
      default: return plain_byte();
    endcase
  endfunction

  // wait until every queued request is accepted, so the predicted state is current
  task automatic wait_sender_idle();
    do @(negedge clk_i); while (pending_q.size() != 0 || s_valid);
  endtask

  initial begin
    int unsigned n;
    int unsigned m;
    int unsigned k;
    int unsigned open;
    int unsigned lim;
    int unsigned fault_kind;
    logic [15:0] lp;
    bit          right;
    bit          pressure_done;

    foreach (tape_mem[i]) tape_mem[i] = 8'd0;
    foreach (loop_starts[i]) loop_starts[i] = 16'd0;
    pressure_done = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    push_full(CMD_OUTPUT,   16'h0000, 8'h00);
    push_full(CMD_INPUT,    16'h0001, 8'hFF);
    push_full(CMD_OUTPUT,   16'hFFFF, 8'h00);
    push_full(CMD_CELL_INC, 16'h0003, 8'hFF);
    push_full(CMD_OUTPUT,   16'h0004, 8'h00);
    push_full(CMD_CELL_DEC, 16'h0005, 8'hFF);
    push_full(CMD_LOOP_BEG, 16'hFFFF, 8'h00);
    push_full(CMD_LOOP_END, 16'h0007, 8'hFF);
    push_full(CMD_INPUT,    16'h0000, 8'h00);
    push_full(CMD_LOOP_END, 16'h0009, 8'hFF);
    push_full(CMD_PTR_INC,  16'h000A, 8'h00);
    push_full(CMD_INPUT,    16'h000B, 8'hA5);
    push_full(CMD_OUTPUT,   16'h000C, 8'h5A);
    push_full(CMD_PTR_DEC,  16'h000D, 8'hFF);
    push_full(CMD_OUTPUT,   16'h000E, 8'h00);
    push_full(CMD_LOOP_BEG, 16'h000F, 8'hFF);
    push_full(8'h00,        16'h0010, 8'h00);
    push_full(CMD_LOOP_BEG, 16'h0011, 8'hFF);
    push_full(CMD_OUTPUT,   16'h0012, 8'h00);
    push_full(CMD_LOOP_END, 16'h0013, 8'hFF);
    push_full(CMD_LOOP_END, 16'h0014, 8'h00);
    push_full(8'hFF,        16'h8000, 8'hFF);
    push_full(CMD_OUTPUT,   16'h7FFF, 8'h00);
    wait_sender_idle();
    cmds_sent = 0;

    while (cmds_sent < RandomCmds) begin
      wait_sender_idle();
      if (skip_mode) begin
        repeat (skip_depth + 1) push_cmd(CMD_LOOP_END);
        wait_sender_idle();
      end
      if (!pressure_done && cmds_sent >= RandomCmds / 2) begin
        pressure_done = 1'b1;
        steady = 1'b1;
        hold_reqs++;
        repeat (40) push_cmd(cell_op());
        wait_sender_idle();
        steady = 1'b0;
      end
      case ($urandom_range(0, 3))
        0: begin
          repeat ($urandom_range(1, 8)) push_cmd(cell_op());
        end
        1: begin
          right = (cell_ptr == 0) ? 1'b1 : 1'($urandom);
          lim = right ? TapeCells - 1 - cell_ptr : cell_ptr;
          k = $urandom_range(1, 12);
          if (k > lim) k = lim;
          repeat (k) begin
            push_cmd(right ? CMD_PTR_INC : CMD_PTR_DEC);
            if ($urandom_range(0, 9) < 3) push_cmd(cell_op());
          end
        end
        2: begin
          n = (loop_count >= LoopDepth) ? 0 : $urandom_range(0, 4);
          lp = 16'($urandom);
          push_full(CMD_INPUT, 16'($urandom), 8'(n));
          push_full(CMD_LOOP_BEG, lp, 8'($urandom));
          if (n == 0) begin
            open = 0;
            repeat ($urandom_range(1, 10)) begin
              case ($urandom_range(0, 2))
                0: begin
                  push_cmd(CMD_LOOP_BEG);
                  open++;
                end
                1: if (open > 0) begin
                  push_cmd(CMD_LOOP_END);
                  open--;
                end
                default: push_cmd(skip_byte());
              endcase
            end
            repeat (open + 1) push_cmd(CMD_LOOP_END);
          end else begin
            repeat (n) begin
              if (cell_ptr < TapeCells - 1) begin
                push_cmd(CMD_PTR_INC);
                repeat ($urandom_range(0, 3)) push_cmd(CMD_CELL_INC);
                push_cmd(CMD_OUTPUT);
                push_cmd(CMD_PTR_DEC);
              end
              push_cmd(CMD_OUTPUT);
              if ($urandom_range(0, 1)) push_cmd(plain_byte());
              push_cmd(CMD_CELL_DEC);
              push_cmd(CMD_LOOP_END);
            end
          end
        end
        default: begin
          m = 0;
          if (loop_count < LoopDepth) begin
            m = ($urandom_range(0, 3) == 0) ? LoopDepth - loop_count :
                $urandom_range(1, LoopDepth - loop_count);
          end
          push_full(CMD_INPUT, 16'($urandom), 8'($urandom_range(1, 255)));
          repeat (m) push_cmd(CMD_LOOP_BEG);
          if (loop_count + m > 0 && $urandom_range(0, 1)) push_cmd(CMD_LOOP_END);
          push_full(CMD_INPUT, 16'($urandom), 8'h00);
          repeat ($urandom_range(0, loop_count + m)) push_cmd(CMD_LOOP_END);
        end
      endcase
    end

    // nest the skip several levels deep, then unwind it
    wait_sender_idle();
    if (skip_mode) begin
      repeat (skip_depth + 1) push_cmd(CMD_LOOP_END);
      wait_sender_idle();
    end
    steady = 1'b1;
    push_full(CMD_INPUT, 16'($urandom), 8'h00);
    push_cmd(CMD_LOOP_BEG);
    repeat (20) push_cmd(CMD_LOOP_BEG);
    repeat (20) push_cmd(CMD_LOOP_END);
    push_cmd(CMD_OUTPUT);
    push_cmd(CMD_LOOP_END);
    push_cmd(CMD_OUTPUT);
    wait_sender_idle();

    // end with one fault, then confirm the halt holds
    fault_kind = $urandom_range(0, 3);
    if (fault_kind == 0 && TapeCells - cell_ptr > 64) fault_kind = 1;
    case (fault_kind)
      0: repeat (TapeCells - cell_ptr) push_cmd(CMD_PTR_INC);
      1: repeat (cell_ptr + 1) push_cmd(CMD_PTR_DEC);
      2: begin
        push_full(CMD_INPUT, 16'($urandom), 8'h00);
        repeat (loop_count + 1) push_cmd(CMD_LOOP_END);
      end
      default: begin
        push_full(CMD_INPUT, 16'($urandom), 8'($urandom_range(1, 255)));
        repeat (LoopDepth - loop_count + 1) push_cmd(CMD_LOOP_BEG);
      end
    endcase
    wait_sender_idle();
    steady = 1'b0;
    repeat (12) push_full(8'($urandom), 16'($urandom), 8'($urandom));
    push_cmd(CMD_OUTPUT);
    push_cmd(CMD_LOOP_BEG);

    wait_sender_idle();
    while (expected_results_q.size() != 0) @(negedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* brainfuck_instruction_executor.f */
rtl/bfie_pkg.sv
rtl/bfie_tape.sv
rtl/bfie_stack.sv
rtl/brainfuck_instruction_executor.sv
tb/tb_top.sv
